// ===== hw/rtl/sal_pkg.sv =====
// shared types and constants for the skyline atlas allocator
package sal_pkg;

   // fixed widths of the request and result fields
   localparam int REQ_W = 10;
   localparam int POS_W = 9;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_PLACED  = 2'd0,
      STATUS_EMPTY   = 2'd1,
      STATUS_NO_ROOM = 2'd2
   } alloc_status_type;

   // per-cycle control from the sequencer to the span unit
   typedef struct packed {
      logic init;     // clear the best-corner tracker
      logic vld;      // a skyline word arrives this cycle
      logic fwd;      // forward pass (prefix max and window compare)
      logic brk;      // block boundary: restart the running max
      logic win_vld;  // a full window ends at this column
   } span_ctl_type;

endpackage

// ===== hw/rtl/sal_ram.sv =====
// generic single-write, single-read memory with registered read data
module sal_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/sal_span.sv =====
// running block max, sliding window max and leftmost-lowest corner tracking
module sal_span #(
   parameter int ATLAS_SIZE = 512
) (
   input  logic                              clock,
   input  logic                              reset,
   input  sal_pkg::span_ctl_type             ctl,
   input  logic [$clog2(ATLAS_SIZE)-1:0]     win_u,
   input  logic [$clog2(ATLAS_SIZE+1)-1:0]   hgt_rd,
   input  logic [$clog2(ATLAS_SIZE+1)-1:0]   sfx_rd,
   output logic [$clog2(ATLAS_SIZE+1)-1:0]   run_max,
   output logic [$clog2(ATLAS_SIZE)-1:0]     best_u,
   output logic [$clog2(ATLAS_SIZE+1)-1:0]   best_v
);

   import sal_pkg::*;

   localparam int AW = $clog2(ATLAS_SIZE);
   localparam int HW = $clog2(ATLAS_SIZE + 1);
   localparam logic [HW-1:0] HGT_FULL = HW'(ATLAS_SIZE);

   logic [HW-1:0] run_ff, run_in;
   logic [HW-1:0] win;
   logic [HW-1:0] win_ff;
   logic [AW-1:0] win_u_ff;
   logic          win_vld_ff, win_vld_in;
   logic [HW-1:0] best_v_ff, best_v_in;
   logic [AW-1:0] best_u_ff, best_u_in;

   // suffix max on the backward pass, prefix max on the forward pass
   always_comb begin
      if (ctl.brk || hgt_rd > run_ff) begin
         run_max = hgt_rd;
      end else begin
         run_max = run_ff;
      end
      run_in = ctl.vld ? run_max : run_ff;
      win = (run_max > sfx_rd) ? run_max : sfx_rd;
      win_vld_in = ctl.vld && ctl.fwd && ctl.win_vld;
   end

   // strict less keeps the leftmost of equal spans
   always_comb begin
      best_v_in = best_v_ff;
      best_u_in = best_u_ff;
      if (ctl.init) begin
         best_v_in = HGT_FULL;
         best_u_in = '0;
      end else if (win_vld_ff && win_ff < best_v_ff) begin
         best_v_in = win_ff;
         best_u_in = win_u_ff;
      end
   end

   always_ff @(posedge clock) begin
      run_ff    <= run_in;
      win_ff    <= win;
      win_u_ff  <= win_u;
      best_v_ff <= best_v_in;
      best_u_ff <= best_u_in;
      if (reset) begin
         win_vld_ff <= 1'b0;
      end else begin
         win_vld_ff <= win_vld_in;
      end
   end

   assign best_u = best_u_ff;
   assign best_v = best_v_ff;

endmodule

// ===== hw/rtl/skyline_atlas_allocator_core.sv =====
// top level of the skyline atlas allocator: sequencer, skyline and suffix memories
//
// places rectangles bottom-left in a square atlas of ATLAS_SIZE columns. a
// transaction is taken when start is high and busy is low; its result comes
// back as a one-cycle rsp_valid strobe that the receiver cannot stall, so it
// must take every strobe. zero-sized and too-wide requests answer on the cycle
// after acceptance and leave busy low. every other request runs two passes
// over the skyline memory: a backward pass that builds per-block suffix maxima
// into a second memory, a forward pass that forms prefix maxima and the window
// max of each start column, then, when the rectangle fits below the top edge, a
// write-back of rect_width columns.
// after reset a clearing pass loads the skyline (column 0 at height 1, the rest
// at 0) while busy is high. place_u and place_v are the low 9 bits of the corner
// and are zero unless the status is placed.
module skyline_atlas_allocator_core #(
   parameter int ATLAS_SIZE = 512
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [sal_pkg::REQ_W-1:0]      req_rect_width,
   input  logic [sal_pkg::REQ_W-1:0]      req_rect_height,
   output logic                           rsp_valid,
   output logic [sal_pkg::POS_W-1:0]      rsp_place_u,
   output logic [sal_pkg::POS_W-1:0]      rsp_place_v,
   output sal_pkg::alloc_status_type      rsp_alloc_status
);

   import sal_pkg::*;

   localparam int AW = $clog2(ATLAS_SIZE);
   localparam int HW = $clog2(ATLAS_SIZE + 1);
   localparam int SW = ((HW > REQ_W) ? HW : REQ_W) + 1;
   localparam logic [AW-1:0] LAST_ADR = AW'(ATLAS_SIZE - 1);
   localparam logic [SW-1:0] TOP = SW'(ATLAS_SIZE);
   localparam logic [HW-1:0] HGT_FULL = HW'(ATLAS_SIZE);

   typedef enum logic [3:0] {
      CLEAR,
      IDLE,
      SFX_SCAN,
      SFX_DRAIN,
      FWD_SCAN,
      FWD_DRAIN,
      FWD_PICK,
      CHECK,
      WRITE
   } state_type;

   state_type        state_ff, state_in;
   logic [AW-1:0]    a_ff, a_in;        // shared sweep address
   logic [AW-1:0]    dist_ff, dist_in;  // distance to the end of the current block
   logic [AW-1:0]    cnt_ff, cnt_in;    // write-back columns left
   logic [REQ_W-1:0] w_ff, w_in;
   logic [REQ_W-1:0] h_ff, h_in;
   logic [HW-1:0]    wval_ff, wval_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0] rsp_u_ff, rsp_u_in;
   logic [POS_W-1:0] rsp_v_ff, rsp_v_in;
   alloc_status_type rsp_status_ff, rsp_status_in;

   // read-data stage that lines up with the memory latency
   logic             s1_vld_ff, s1_vld_in;
   logic             s1_fwd_ff, s1_fwd_in;
   logic             s1_brk_ff, s1_brk_in;
   logic             s1_wv_ff, s1_wv_in;
   logic [AW-1:0]    s1_idx_ff;
   logic [AW-1:0]    s1_u_ff;

   logic             scan_init;
   logic [SW-1:0]    w_ext;
   logic [AW-1:0]    wm1;
   logic [AW-1:0]    fwd_u;
   logic [SW-1:0]    fit_sum;

   logic             hgt_we;
   logic [HW-1:0]    hgt_wdata;
   logic [HW-1:0]    hgt_rd;
   logic             sfx_we;
   logic [HW-1:0]    sfx_rd;
   logic [HW-1:0]    run_max;
   logic [AW-1:0]    best_u;
   logic [HW-1:0]    best_v;
   span_ctl_type     span_ctl;

   assign w_ext   = SW'(w_ff);
   assign wm1     = AW'(w_ext - SW'(1));
   assign fwd_u   = a_ff - wm1;           // start column of the window ending here
   assign fit_sum = SW'(best_v) + SW'(h_ff);

   always_comb begin
      state_in      = state_ff;
      a_in          = a_ff;
      dist_in       = dist_ff;
      cnt_in        = cnt_ff;
      w_in          = w_ff;
      h_in          = h_ff;
      wval_in       = wval_ff;
      rsp_valid_in  = 1'b0;
      rsp_u_in      = '0;
      rsp_v_in      = '0;
      rsp_status_in = STATUS_PLACED;
      s1_vld_in     = 1'b0;
      s1_fwd_in     = 1'b0;
      s1_brk_in     = 1'b0;
      s1_wv_in      = 1'b0;
      scan_init     = 1'b0;
      hgt_we        = 1'b0;
      hgt_wdata     = wval_ff;

      case (state_ff)
         CLEAR: begin
            // reserved corner texel in column 0
            hgt_we    = 1'b1;
            hgt_wdata = (a_ff == '0) ? HW'(1) : '0;
            a_in      = a_ff + AW'(1);
            if (a_ff == LAST_ADR) begin
               state_in = IDLE;
            end
         end
         IDLE: begin
            if (start) begin
               w_in = req_rect_width;
               h_in = req_rect_height;
               if (req_rect_width == '0 || req_rect_height == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_EMPTY;
               end else if (SW'(req_rect_width) > TOP) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_NO_ROOM;
               end else begin
                  scan_init = 1'b1;
                  a_in      = LAST_ADR;
                  dist_in   = '0;
                  state_in  = SFX_SCAN;
               end
            end
         end
         SFX_SCAN: begin
            // blocks are aligned to the right edge of the atlas
            s1_vld_in = 1'b1;
            s1_brk_in = (dist_ff == '0);
            if (a_ff == '0) begin
               state_in = SFX_DRAIN;
            end else begin
               a_in    = a_ff - AW'(1);
               dist_in = (dist_ff == wm1) ? '0 : dist_ff + AW'(1);
            end
         end
         SFX_DRAIN: begin
            // last suffix word lands in memory at the end of this cycle
            a_in     = '0;
            state_in = FWD_SCAN;
         end
         FWD_SCAN: begin
            s1_vld_in = 1'b1;
            s1_fwd_in = 1'b1;
            s1_brk_in = (a_ff == '0) || (dist_ff == wm1);
            s1_wv_in  = (a_ff >= wm1);
            dist_in   = (dist_ff == '0) ? wm1 : dist_ff - AW'(1);
            if (a_ff == LAST_ADR) begin
               state_in = FWD_DRAIN;
            end else begin
               a_in = a_ff + AW'(1);
            end
         end
         FWD_DRAIN: begin
            state_in = FWD_PICK;
         end
         FWD_PICK: begin
            state_in = CHECK;
         end
         CHECK: begin
            // top edge check; a full column leaves best_v at the atlas size
            if (fit_sum > TOP) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_NO_ROOM;
               state_in      = IDLE;
            end else begin
               wval_in  = HW'(fit_sum);
               a_in     = best_u;
               cnt_in   = wm1;
               state_in = WRITE;
            end
         end
         WRITE: begin
            hgt_we = 1'b1;
            a_in   = a_ff + AW'(1);
            cnt_in = cnt_ff - AW'(1);
            if (cnt_ff == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_u_in      = POS_W'(best_u);
               rsp_v_in      = POS_W'(best_v);
               rsp_status_in = STATUS_PLACED;
               state_in      = IDLE;
            end
         end
         default: begin
            state_in = CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      dist_ff       <= dist_in;
      cnt_ff        <= cnt_in;
      w_ff          <= w_in;
      h_ff          <= h_in;
      wval_ff       <= wval_in;
      rsp_u_ff      <= rsp_u_in;
      rsp_v_ff      <= rsp_v_in;
      rsp_status_ff <= rsp_status_in;
      s1_fwd_ff     <= s1_fwd_in;
      s1_brk_ff     <= s1_brk_in;
      s1_wv_ff      <= s1_wv_in;
      s1_idx_ff     <= a_ff;
      s1_u_ff       <= fwd_u;
      if (reset) begin
         state_ff     <= CLEAR;
         a_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         s1_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         a_ff         <= a_in;
         rsp_valid_ff <= rsp_valid_in;
         s1_vld_ff    <= s1_vld_in;
      end
   end

   assign busy             = (state_ff != IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_place_u      = rsp_u_ff;
   assign rsp_place_v      = rsp_v_ff;
   assign rsp_alloc_status = rsp_status_ff;

   // suffix words are written only on the backward pass
   assign sfx_we = s1_vld_ff && !s1_fwd_ff;

   assign span_ctl.init    = scan_init;
   assign span_ctl.vld     = s1_vld_ff;
   assign span_ctl.fwd     = s1_fwd_ff;
   assign span_ctl.brk     = s1_brk_ff;
   assign span_ctl.win_vld = s1_wv_ff;

   // skyline: one filled height per column
   sal_ram #(
      .WIDTH(HW),
      .DEPTH(ATLAS_SIZE)
   ) u_hgt_ram (
      .clock(clock),
      .we   (hgt_we),
      .waddr(a_ff),
      .wdata(hgt_wdata),
      .raddr(a_ff),
      .rdata(hgt_rd)
   );

   // per-block suffix maxima of the skyline
   sal_ram #(
      .WIDTH(HW),
      .DEPTH(ATLAS_SIZE)
   ) u_sfx_ram (
      .clock(clock),
      .we   (sfx_we),
      .waddr(s1_idx_ff),
      .wdata(run_max),
      .raddr(fwd_u),
      .rdata(sfx_rd)
   );

   sal_span #(
      .ATLAS_SIZE(ATLAS_SIZE)
   ) u_span (
      .clock  (clock),
      .reset  (reset),
      .ctl    (span_ctl),
      .win_u  (s1_u_ff),
      .hgt_rd (hgt_rd),
      .sfx_rd (sfx_rd),
      .run_max(run_max),
      .best_u (best_u),
      .best_v (best_v)
   );

   // rejected transactions carry a zero corner
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_alloc_status != STATUS_PLACED
      |-> rsp_place_u == '0 && rsp_place_v == '0)
      else $error("rejected transaction with nonzero corner");

   // an accepted transaction either answers at once or keeps the block busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> rsp_valid || busy)
      else $error("accepted transaction dropped");

   // suffix memory is never written once the forward pass reads it
   a_sfx_write_window: assert property (@(posedge clock) disable iff (reset)
      sfx_we |-> state_ff == SFX_SCAN || state_ff == SFX_DRAIN)
      else $error("suffix write overlaps forward pass");

   // a found corner leaves room for the whole width
   a_span_fits: assert property (@(posedge clock) disable iff (reset)
      state_ff == CHECK && best_v != HGT_FULL |-> (SW'(best_u) + w_ext) <= TOP)
      else $error("chosen span runs past the right edge");

endmodule

// ===== dv/tb.sv =====
// testbench for skyline_atlas_allocator_core: directed table plus random rectangles vs. a skyline predictor
`timescale 1ns / 1ps

module tb;
   import sal_pkg::*;

   localparam int ATLAS     = 512;
   localparam int N_DIR     = 21;
   localparam int N_RANDOM  = 520;
   // sender idle percentage per random phase: none, heavy, light
   localparam int IDLE_PCT [3] = '{0, 53, 7};

   // one row of the directed table; when has_exp is set the corner is typed in,
   // otherwise the predictor supplies it
   typedef struct packed {
      logic [REQ_W-1:0] w;
      logic [REQ_W-1:0] h;
      logic             has_exp;
      logic [POS_W-1:0] u;
      logic [POS_W-1:0] v;
      alloc_status_type st;
   } rect_row_type;

   typedef struct packed {
      logic [POS_W-1:0] u;
      logic [POS_W-1:0] v;
      alloc_status_type st;
   } corner_type;

   // walk of the special cases right after reset, while the skyline is still flat
   localparam rect_row_type DIR_ROWS [N_DIR] = '{
      // zero size in either field, including a too-wide width with zero height
      '{10'd0,    10'd0,    1'b1, 9'd0, 9'd0, STATUS_EMPTY},
      '{10'd0,    10'd1023, 1'b1, 9'd0, 9'd0, STATUS_EMPTY},
      '{10'd1023, 10'd0,    1'b1, 9'd0, 9'd0, STATUS_EMPTY},
      // wider than the atlas
      '{10'd513,  10'd1,    1'b1, 9'd0, 9'd0, STATUS_NO_ROOM},
      '{10'd1023, 10'd1023, 1'b1, 9'd0, 9'd0, STATUS_NO_ROOM},
      // column 0 holds the reserved texel, so the first unit square lands at column 1
      '{10'd1,    10'd1,    1'b1, 9'd1, 9'd0, STATUS_PLACED},
      // full width sits on top of the highest column
      '{10'd512,  10'd1,    1'b1, 9'd0, 9'd1, STATUS_PLACED},
      // would pass the top edge by one row
      '{10'd512,  10'd511,  1'b1, 9'd0, 9'd0, STATUS_NO_ROOM},
      // reaches the top edge exactly
      '{10'd1,    10'd510,  1'b1, 9'd0, 9'd2, STATUS_PLACED},
      // the rest depend on the skyline built above
      '{10'd512,  10'd1,    1'b0, 9'd0, 9'd0, STATUS_PLACED},
      '{10'd511,  10'd1,    1'b0, 9'd0, 9'd0, STATUS_PLACED},
      '{10'd1,    10'd512,  1'b0, 9'd0, 9'd0, STATUS_PLACED},
      '{10'd1,    10'd1,    1'b0, 9'd0, 9'd0, STATUS_PLACED},
      '{10'd2,    10'd4,    1'b0, 9'd0, 9'd0, STATUS_PLACED},
      '{10'd3,    10'd1,    1'b0, 9'd0, 9'd0, STATUS_PLACED},
      '{10'd511,  10'd2,    1'b0, 9'd0, 9'd0, STATUS_PLACED},
      '{10'd256,  10'd100,  1'b0, 9'd0, 9'd0, STATUS_PLACED},
      '{10'd256,  10'd100,  1'b0, 9'd0, 9'd0, STATUS_PLACED},
      '{10'd511,  10'd404,  1'b0, 9'd0, 9'd0, STATUS_PLACED},
      '{10'd7,    10'd1,    1'b0, 9'd0, 9'd0, STATUS_PLACED},
      '{10'd64,   10'd32,   1'b0, 9'd0, 9'd0, STATUS_PLACED}
   };

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic [REQ_W-1:0] req_rect_width = '0;
   logic [REQ_W-1:0] req_rect_height = '0;
   logic             busy;
   logic             rsp_valid;
   logic [POS_W-1:0] rsp_place_u;
   logic [POS_W-1:0] rsp_place_v;
   alloc_status_type rsp_alloc_status;

   // predicted skyline: filled height per column
   int         skyline [ATLAS];
   // corners still owed by the block, oldest first
   corner_type pending_corners [$];
   int         mismatches = 0;
   int         idle_pct = 0;

   skyline_atlas_allocator_core #(
      .ATLAS_SIZE (ATLAS)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_rect_width   (req_rect_width),
      .req_rect_height  (req_rect_height),
      .rsp_valid        (rsp_valid),
      .rsp_place_u      (rsp_place_u),
      .rsp_place_v      (rsp_place_v),
      .rsp_alloc_status (rsp_alloc_status)
   );

   // 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // bottom-left placement over the predicted skyline; raises the covered
   // columns when the rectangle is placed
   function automatic corner_type place_rect(input logic [REQ_W-1:0] w,
                                             input logic [REQ_W-1:0] h);
      corner_type res;
      int         wi;
      int         hi;
      int         best_u;
      int         best_v;
      int         span_max;
      wi     = int'(w);
      hi     = int'(h);
      best_u = 0;
      // nothing can sit at the top edge, so this doubles as "no span found"
      best_v = ATLAS;
      res.u  = '0;
      res.v  = '0;
      res.st = STATUS_NO_ROOM;
      if (wi == 0 || hi == 0) begin
         res.st = STATUS_EMPTY;
      end else if (wi <= ATLAS) begin
         for (int u = 0; u + wi <= ATLAS; u++) begin
            span_max = 0;
            for (int k = 0; k < wi; k++) begin
               if (skyline[u + k] > span_max) span_max = skyline[u + k];
            end
            // strict compare keeps the leftmost of equal spans
            if (span_max < best_v) begin
               best_v = span_max;
               best_u = u;
            end
         end
         if (best_v + hi <= ATLAS) begin
            for (int k = 0; k < wi; k++) skyline[best_u + k] = best_v + hi;
            res.u  = best_u[POS_W-1:0];
            res.v  = best_v[POS_W-1:0];
            res.st = STATUS_PLACED;
         end
      end
      return res;
   endfunction

   // present one rectangle from a falling edge and hold it until the block takes it;
   // returns at the falling edge after acceptance, start still high
   task automatic feed_rect(input logic [REQ_W-1:0] w, input logic [REQ_W-1:0] h,
                            input logic has_exp, input corner_type typed);
      corner_type predicted;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start           <= 1'b1;
      req_rect_width  <= w;
      req_rect_height <= h;
      do @(posedge clock); while (busy !== 1'b0);
      // accepted at this edge: the predictor always runs so the skyline stays in step
      predicted = place_rect(w, h);
      pending_corners.push_back(has_exp ? typed : predicted);
      @(negedge clock);
   endtask

   // result checker: every strobe must match the oldest owed corner
   always @(posedge clock) begin
      corner_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_corners.size() == 0) begin
            $display("%0t: unexpected result u=%0d v=%0d status=%0d", $time,
                     rsp_place_u, rsp_place_v, rsp_alloc_status);
            mismatches++;
         end else begin
            want = pending_corners.pop_front();
            if (rsp_place_u !== want.u) begin
               $display("%0t: place_u expected %0d got %0d", $time, want.u, rsp_place_u);
               mismatches++;
            end
            if (rsp_place_v !== want.v) begin
               $display("%0t: place_v expected %0d got %0d", $time, want.v, rsp_place_v);
               mismatches++;
            end
            if (rsp_alloc_status !== want.st) begin
               $display("%0t: alloc_status expected %0d got %0d", $time, want.st,
                        rsp_alloc_status);
               mismatches++;
            end
         end
      end
   end

   // stimulus: directed table first, then three random phases of sender idling
   initial begin
      corner_type       typed;
      logic [REQ_W-1:0] w;
      logic [REQ_W-1:0] h;
      int               sel;
      // skyline after reset: reserved texel at column 0
      for (int c = 0; c < ATLAS; c++) skyline[c] = 0;
      skyline[0] = 1;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part, back to back; the clearing pass holds busy until it is done
      for (int i = 0; i < N_DIR; i++) begin
         typed.u  = DIR_ROWS[i].u;
         typed.v  = DIR_ROWS[i].v;
         typed.st = DIR_ROWS[i].st;
         feed_rect(DIR_ROWS[i].w, DIR_ROWS[i].h, DIR_ROWS[i].has_exp, typed);
      end

      // random part: mostly small rectangles so the atlas fills slowly and the
      // search sees a ragged skyline; the rest covers zero size, too wide,
      // wide spans and heights that pass the top edge
      typed = '0;
      for (int i = 0; i < N_RANDOM; i++) begin
         idle_pct = IDLE_PCT[(i * 3) / N_RANDOM];
         sel = $urandom_range(99);
         if (sel < 3) begin
            w = '0;
            h = REQ_W'($urandom_range(1023));
         end else if (sel < 6) begin
            w = REQ_W'($urandom_range(1023));
            h = '0;
         end else if (sel < 11) begin
            w = REQ_W'($urandom_range(1023, 513));
            h = REQ_W'($urandom_range(1023));
         end else if (sel < 15) begin
            w = REQ_W'($urandom_range(ATLAS, 1));
            h = $urandom_range(1) ? REQ_W'($urandom_range(8, 1))
                                  : REQ_W'($urandom_range(1023, 400));
         end else if (sel < 30) begin
            w = REQ_W'($urandom_range(8, 1));
            h = REQ_W'($urandom_range(8, 1));
         end else begin
            w = REQ_W'($urandom_range(48, 1));
            h = REQ_W'($urandom_range(24, 1));
         end
         feed_rect(w, h, 1'b0, typed);
      end
      start <= 1'b0;

      // drain, then give a full worst-case item time for a stray strobe to show up
      while (pending_corners.size() != 0) @(posedge clock);
      repeat (3 * ATLAS + 16) @(posedge clock);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // run limit, several times the slowest correct run (clearing pass included)
   initial begin
      #10_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
